[rtl/core/lru_replacement_tracker_assert.svh]
// ----------------------------------------------------------------------------
// LRU replacement tracker assertion macros
// Shared property forms for the port checker of the tracker.
// ----------------------------------------------------------------------------
`ifndef LRU_REPLACEMENT_TRACKER_ASSERT_SVH
`define LRU_REPLACEMENT_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lru tracker port check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lru tracker port check failed");

`define LRT_ASSERT_TWO(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("lru tracker port check failed");

`endif

[rtl/core/lrt_pkg.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker package
// Sizes, field widths and the control word broadcast to the entry cells.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int KEY_BITS    = 16;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CAP_W  = 5;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam int ACCESS_KEY_W = 16;
  localparam int HIT_RANK_W   = 4;
  localparam int OCCUPANCY_W  = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic                probe;
    logic                update;
    logic [KEY_BITS-1:0] key;
    logic [CNT_W-1:0]    count;
    logic [CNT_W-1:0]    limit;
  } lrt_ctrl_t;

endpackage

[rtl/core/lrt_cell.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker entry cell
// Holds one key of the recency list, compares it against the access and
// takes its neighbor's key when the list shifts.
// ----------------------------------------------------------------------------
module lrt_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lrt_pkg::IDX_W-1:0]    idx,
  input  lrt_pkg::lrt_ctrl_t           ctrl,
  input  logic [lrt_pkg::KEY_BITS-1:0] prev_key,
  output logic [lrt_pkg::KEY_BITS-1:0] key,
  output logic                        match
);
  import lrt_pkg::*;

  logic [KEY_BITS-1:0] key_r;
  logic                match_r;
  logic [CNT_W-1:0]    pos;

  assign pos   = CNT_W'(idx);
  assign key   = key_r;
  assign match = match_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.probe) begin
      match_r <= (key_r == ctrl.key) && (pos < ctrl.count);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (pos == '0) begin
        key_r <= ctrl.key;
      end else if (pos <= ctrl.limit) begin
        key_r <= prev_key;
      end
    end
  end

endmodule

[rtl/core/lru_replacement_tracker.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker
// Recency-ordered key list held in a row of entry cells.
// ----------------------------------------------------------------------------
// An access word is taken at a rising edge where start is high and busy is
// low; in_access_key carries the key. At that edge every cell registers the
// compare of its key with the access; then, in the update state, the match
// vector is encoded and the list shifts one place toward the tail, the
// accessed key landing at the front. busy is high in the update state only.
// The result word appears on the out_ ports with out_valid high for exactly
// one cycle; out_valid and the word are registered at the end of the update
// state, and the word is accepted at the rising edge that ends the pulse.
// The receiver cannot stall it, and no result is ever held back. A new
// access is taken only once the list has shifted for the last one.
// cfg_we writes cfg_capacity, the number of keys held before a miss evicts
// the least recent one; write it only while the block is idle.
// Synchronous reset empties the list, sets the capacity to 16 and leaves the
// block idle. Stored keys are not cleared; the count hides them.
// ----------------------------------------------------------------------------
module lru_replacement_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lrt_pkg::CAP_W-1:0]        cfg_capacity,
  input  logic                            start,
  output logic                            busy,
  input  logic [lrt_pkg::ACCESS_KEY_W-1:0] in_access_key,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [lrt_pkg::HIT_RANK_W-1:0]   out_hit_rank,
  output logic                            out_hit_was_oldest,
  output logic                            out_evicted,
  output logic [lrt_pkg::ACCESS_KEY_W-1:0] out_evicted_key,
  output logic [lrt_pkg::OCCUPANCY_W-1:0]  out_occupancy
);
  import lrt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } lrt_state_t;

  lrt_state_t          state_r, state_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CAP_W-1:0]    cap_r;

  logic                    accept;
  logic [KEY_BITS+15:0]    in_key_wide;
  logic [KEY_BITS-1:0]     in_key;
  lrt_ctrl_t               ctrl;
  logic [KEY_BITS-1:0]     cell_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]  cell_match;

  logic                    hit;
  logic [IDX_W-1:0]        rank;
  logic [CNT_W-1:0]        rank_ext;
  logic [CMP_W-1:0]        cap_ext, cap_eff, count_cmp;
  logic                    evict;
  logic [CNT_W-1:0]        count_m1;
  logic [CNT_W-1:0]        n_after;
  logic                    oldest;
  logic [KEY_BITS-1:0]     tail_key;
  logic [KEY_BITS+15:0]    ev_key_wide;
  logic [IDX_W+3:0]        rank_wide;
  logic [CNT_W+4:0]        occ_wide;

  assign accept      = start && (state_r == ST_IDLE);
  assign busy        = (state_r == ST_UPDATE);
  assign in_key_wide = {{KEY_BITS{1'b0}}, in_access_key};
  assign in_key      = in_key_wide[KEY_BITS-1:0];

  always_comb begin
    hit  = 1'b0;
    rank = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (cell_match[i]) begin
        hit  = 1'b1;
        rank = rank | IDX_W'(i);
      end
    end
  end

  assign rank_ext  = CNT_W'(rank);
  assign cap_ext   = CMP_W'(cap_r);
  assign count_cmp = CMP_W'(count_r);
  assign count_m1  = count_r - 1'b1;

  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_eff = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_eff = cap_ext;
    end
  end

  assign evict    = !hit && (count_cmp >= cap_eff);
  assign n_after  = evict ? count_m1 : count_r;
  assign oldest   = hit && (rank_ext != '0) && (rank_ext == count_m1);
  assign tail_key = cell_key[count_m1[IDX_W-1:0]];

  assign ctrl.probe  = accept;
  assign ctrl.update = (state_r == ST_UPDATE);
  assign ctrl.key    = (state_r == ST_UPDATE) ? key_r : in_key;
  assign ctrl.count  = count_r;
  assign ctrl.limit  = hit ? rank_ext : n_after;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    lrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (IDX_W'(g)),
      .ctrl     (ctrl),
      .prev_key ((g == 0) ? ctrl.key : cell_key[(g == 0) ? 0 : g - 1]),
      .key      (cell_key[g]),
      .match    (cell_match[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_IDLE;
        if (!hit) begin
          count_nxt = n_after + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cap_r     <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_valid <= (state_r == ST_UPDATE);
      if (cfg_we) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_key;
    end
  end

  assign ev_key_wide = {16'b0, (evict ? tail_key : {KEY_BITS{1'b0}})};
  assign rank_wide   = {4'b0, (hit ? rank : {IDX_W{1'b0}})};
  assign occ_wide    = {5'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      out_hit            <= hit;
      out_hit_rank       <= rank_wide[HIT_RANK_W-1:0];
      out_hit_was_oldest <= oldest;
      out_evicted        <= evict;
      out_evicted_key    <= ev_key_wide[ACCESS_KEY_W-1:0];
      out_occupancy      <= occ_wide[OCCUPANCY_W-1:0];
    end
  end

endmodule

[rtl/core/lrt_checker.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker port checker
// Watches the top-level ports for handshake timing and result consistency.
// ----------------------------------------------------------------------------
`include "lru_replacement_tracker_assert.svh"

module lrt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_we,
  input logic [lrt_pkg::CAP_W-1:0]        cfg_capacity,
  input logic                            start,
  input logic                            busy,
  input logic [lrt_pkg::ACCESS_KEY_W-1:0] in_access_key,
  input logic                            out_valid,
  input logic                            out_hit,
  input logic [lrt_pkg::HIT_RANK_W-1:0]   out_hit_rank,
  input logic                            out_hit_was_oldest,
  input logic                            out_evicted,
  input logic [lrt_pkg::ACCESS_KEY_W-1:0] out_evicted_key,
  input logic [lrt_pkg::OCCUPANCY_W-1:0]  out_occupancy
);
  import lrt_pkg::*;

  `LRT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `LRT_ASSERT_TWO(a_accept_result, start && !busy, out_valid)
  `LRT_ASSERT_SAME(a_hit_no_evict, out_valid && out_hit, !out_evicted)
  `LRT_ASSERT_SAME(a_no_evict_zero, out_valid && !out_evicted, out_evicted_key == '0)
  `LRT_ASSERT_SAME(a_oldest_is_hit, out_valid && out_hit_was_oldest,
                   out_hit && (out_hit_rank != '0))

endmodule

bind lru_replacement_tracker lrt_checker u_lrt_checker (.*);

[test/lru_recency_checker.sv]
// ----------------------------------------------------------------------------
// LRU recency checker
// Watches the access, result and capacity ports of the tracker, keeps its own
// recency list, predicts the result word of each accepted access and compares
// every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module lru_recency_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [lrt_pkg::CAP_W-1:0]        cfg_capacity,
  input  logic                             start,
  input  logic                             busy,
  input  logic [lrt_pkg::ACCESS_KEY_W-1:0] in_access_key,
  input  logic                             out_valid,
  input  logic                             out_hit,
  input  logic [lrt_pkg::HIT_RANK_W-1:0]   out_hit_rank,
  input  logic                             out_hit_was_oldest,
  input  logic                             out_evicted,
  input  logic [lrt_pkg::ACCESS_KEY_W-1:0] out_evicted_key,
  input  logic [lrt_pkg::OCCUPANCY_W-1:0]  out_occupancy,
  output int                               fail_count,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import lrt_pkg::*;

  typedef struct packed {
    logic                    hit;
    logic [HIT_RANK_W-1:0]   rank;
    logic                    was_oldest;
    logic                    evicted;
    logic [ACCESS_KEY_W-1:0] evicted_key;
    logic [OCCUPANCY_W-1:0]  occupancy;
  } access_result_t;

  logic [KEY_BITS-1:0] recency_list [MAX_ENTRIES];
  int                  held_keys;
  logic [CAP_W-1:0]    capacity;
  access_result_t      expected_results [$];

  function automatic int effective_capacity();
    if (capacity == 0) begin
      return 1;
    end
    if (capacity > MAX_ENTRIES) begin
      return MAX_ENTRIES;
    end
    return int'(capacity);
  endfunction

  function automatic access_result_t predict_access(input logic [ACCESS_KEY_W-1:0] key);
    access_result_t res;
    int             pos;
    int             n;
    res = '0;
    pos = -1;
    for (int i = 0; i < held_keys; i++) begin
      if (pos < 0 && recency_list[i] == key[KEY_BITS-1:0]) begin
        pos = i;
      end
    end
    if (pos >= 0) begin
      res.hit        = 1'b1;
      res.rank       = pos[HIT_RANK_W-1:0];
      res.was_oldest = (pos != 0) && (pos + 1 == held_keys);
      for (int i = pos; i > 0; i--) begin
        recency_list[i] = recency_list[i-1];
      end
      recency_list[0] = key[KEY_BITS-1:0];
    end else begin
      n = held_keys;
      if (n >= effective_capacity() && n > 0) begin
        res.evicted     = 1'b1;
        res.evicted_key = recency_list[n-1];
        n--;
      end
      for (int i = n; i > 0; i--) begin
        recency_list[i] = recency_list[i-1];
      end
      recency_list[0] = key[KEY_BITS-1:0];
      held_keys = n + 1;
    end
    res.occupancy = held_keys[OCCUPANCY_W-1:0];
    return res;
  endfunction

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (!rst_n) begin
      held_keys = 0;
      capacity  = CAP_RESET;
      expected_results.delete();
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result word with no access outstanding, actual key 0x%0h",
                   $time, out_evicted_key);
        end else begin
          want = expected_results.pop_front();
          compare_field("hit", want.hit, out_hit);
          compare_field("hit_rank", want.rank, out_hit_rank);
          compare_field("hit_was_oldest", want.was_oldest, out_hit_was_oldest);
          compare_field("evicted", want.evicted, out_evicted);
          compare_field("evicted_key", want.evicted_key, out_evicted_key);
          compare_field("occupancy", want.occupancy, out_occupancy);
        end
      end
      if (cfg_we) begin
        capacity = cfg_capacity;
      end
      if (start && !busy) begin
        expected_results.push_back(predict_access(in_access_key));
      end
    end
    pending = expected_results.size();
  end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// LRU replacement tracker testbench
// Drives a directed access sequence and then random phases, each under a
// capacity written before it, with random sender gaps in most phases; the
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lrt_pkg::*;

  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int TAIL_CYCLES  = 4;
  localparam int CAP_MIN_REG  = 0;
  localparam int CAP_MAX_REG  = 31;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_capacity = CAP_RESET;
  logic                    start = 1'b0;
  logic                    busy;
  logic [ACCESS_KEY_W-1:0] in_access_key = '0;
  logic                    out_valid;
  logic                    out_hit;
  logic [HIT_RANK_W-1:0]   out_hit_rank;
  logic                    out_hit_was_oldest;
  logic                    out_evicted;
  logic [ACCESS_KEY_W-1:0] out_evicted_key;
  logic [OCCUPANCY_W-1:0]  out_occupancy;
  int                      fail_count;
  int                      pending;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  lru_replacement_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_capacity       (cfg_capacity),
    .start              (start),
    .busy               (busy),
    .in_access_key      (in_access_key),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_hit_rank       (out_hit_rank),
    .out_hit_was_oldest (out_hit_was_oldest),
    .out_evicted        (out_evicted),
    .out_evicted_key    (out_evicted_key),
    .out_occupancy      (out_occupancy)
  );

  lru_recency_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_capacity       (cfg_capacity),
    .start              (start),
    .busy               (busy),
    .in_access_key      (in_access_key),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_hit_rank       (out_hit_rank),
    .out_hit_was_oldest (out_hit_was_oldest),
    .out_evicted        (out_evicted),
    .out_evicted_key    (out_evicted_key),
    .out_occupancy      (out_occupancy),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk) start <= 1'b0;
  endtask

  task automatic send_access(input logic [ACCESS_KEY_W-1:0] key);
    @(negedge clk);
    start         <= 1'b1;
    in_access_key <= key;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we       <= 1'b1;
    cfg_capacity <= value;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  function automatic logic [ACCESS_KEY_W-1:0] pick_key(input logic [ACCESS_KEY_W-1:0] base,
                                                        input int span);
    if ($urandom_range(0, 99) < 85) begin
      return base + ACCESS_KEY_W'($urandom_range(0, span));
    end
    return ACCESS_KEY_W'($urandom);
  endfunction

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                      caps [PHASES];
    int                      eff;
    bit                      gaps_on;
    logic [ACCESS_KEY_W-1:0] base;
    caps = '{1, 16, CAP_MIN_REG, CAP_MAX_REG, 17, 2, 8, 15, 5, 3, 24, 16};
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    send_access(16'h0000);
    send_access(16'h0000);
    send_access(16'hFFFF);
    send_access(16'h0000);
    send_access(16'h0000);
    for (int k = 1; k <= 14; k++) begin
      send_access(ACCESS_KEY_W'(k));
    end
    send_access(16'h8000);
    send_access(16'h0000);
    write_capacity(5'd1);
    send_access(16'h1234);
    send_access(16'h1234);
    send_access(16'h000E);

    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 2) begin
        caps[p] = $urandom_range(CAP_MIN_REG, CAP_MAX_REG);
      end
      write_capacity(CAP_W'(caps[p]));
      eff     = (caps[p] == 0) ? 1 : (caps[p] > MAX_ENTRIES) ? MAX_ENTRIES : caps[p];
      base    = ACCESS_KEY_W'($urandom);
      gaps_on = (p % 3 != 2) && (p != PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (gaps_on && $urandom_range(0, 3) == 0) begin
          idle_cycles($urandom_range(1, 4));
        end
        send_access(pick_key(base, eff + 3));
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lrt_pkg.sv
rtl/core/lrt_cell.sv
rtl/core/lru_replacement_tracker.sv
rtl/core/lrt_checker.sv
test/lru_recency_checker.sv
test/testbench.sv
